### hdl/lpe_pkg.sv
// shared types and constants of the ll(1) predictive parse engine
package lpe_pkg;

    localparam int SYM_W      = 7;
    localparam int LEN_W      = 4;
    localparam int NSYM       = 8;
    localparam int SYMS_W     = SYM_W * NSYM;
    localparam int ENTRY_W    = 1 + LEN_W + SYMS_W;
    localparam int TBL_AW     = 2 * SYM_W;
    localparam int TBL_DEPTH  = 1 << TBL_AW;
    localparam int FLG_DEPTH  = 1 << SYM_W;

    localparam logic [SYM_W-1:0] END_MARK    = 7'h23;
    localparam logic [SYM_W-1:0] IDENT_TOKEN = 7'h69;
    localparam logic [SYM_W-1:0] START_RESET = 7'h45;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_FLAG  = 2'd1;
    localparam logic [1:0] KIND_CHAR  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_MISMATCH = 2'd1;
    localparam logic [1:0] ERR_NO_ENTRY = 2'd2;
    localparam logic [1:0] ERR_LIMIT    = 2'd3;

    typedef struct packed {
        logic               we;
        logic [TBL_AW-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [TBL_AW-1:0]  raddr;
    } tbl_req_t;

    typedef struct packed {
        logic              we;
        logic [SYM_W-1:0]  waddr;
        logic              wdata;
        logic [SYM_W-1:0]  raddr;
    } flg_req_t;

endpackage

### hdl/ll1_predictive_parse_engine_top.sv
// top level of the ll(1) predictive parse engine
// load and flag beats are written from the idle state; a character beat passes a flag check state, then its parse steps
// each parse step is one pop (states pop, stack read, table and flag read) plus one push state per pushed symbol
// end of expression gives its result beat after the steps for a pending 'i' and for '#'
// after reset the parse table is cleared, one entry a cycle, all 16384 entries with the input stalled
// reset seeds the stack with '#' and 'E' and clears all terminal flags
module ll1_predictive_parse_engine_top
    import lpe_pkg::*;
#(
    parameter int STACK_DEPTH  = 64,
    parameter int MAX_PROD_LEN = 8,
    parameter int STEP_LIMIT   = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [SYM_W-1:0]   char_code,
    input  logic [SYM_W-1:0]   lookahead,
    input  logic [LEN_W-1:0]   prod_length,
    input  logic [SYMS_W-1:0]  prod_symbols,
    input  logic               flag_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SYM_W-1:0]   start_symbol,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               accepted,
    output logic [1:0]         error_cause
);

    localparam int AW = $clog2(STACK_DEPTH);

    tbl_req_t           tbl_req;
    flg_req_t           flg_req;
    logic [ENTRY_W-1:0] tbl_q;
    logic               flg_q;
    logic               stk_we;
    logic [AW-1:0]      stk_waddr;
    logic [SYM_W-1:0]   stk_wdata;
    logic [AW-1:0]      stk_raddr;
    logic [SYM_W-1:0]   stk_q;

    lpe_core #(
        .STACK_DEPTH  (STACK_DEPTH),
        .MAX_PROD_LEN (MAX_PROD_LEN),
        .STEP_LIMIT   (STEP_LIMIT)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .char_code    (char_code),
        .lookahead    (lookahead),
        .prod_length  (prod_length),
        .prod_symbols (prod_symbols),
        .flag_value   (flag_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .start_symbol (start_symbol),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .error_cause  (error_cause),
        .tbl_req      (tbl_req),
        .tbl_q        (tbl_q),
        .flg_req      (flg_req),
        .flg_q        (flg_q),
        .stk_we       (stk_we),
        .stk_waddr    (stk_waddr),
        .stk_wdata    (stk_wdata),
        .stk_raddr    (stk_raddr),
        .stk_q        (stk_q)
    );

    lpe_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_table (
        .clk   (clk),
        .we    (tbl_req.we),
        .waddr (tbl_req.waddr),
        .wdata (tbl_req.wdata),
        .raddr (tbl_req.raddr),
        .q     (tbl_q)
    );

    lpe_ram #(.WIDTH(1), .DEPTH(FLG_DEPTH)) u_flags (
        .clk   (clk),
        .we    (flg_req.we),
        .waddr (flg_req.waddr),
        .wdata (flg_req.wdata),
        .raddr (flg_req.raddr),
        .q     (flg_q)
    );

    lpe_ram #(.WIDTH(SYM_W), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .q     (stk_q)
    );

endmodule

### hdl/lpe_ram.sv
// generic single write port ram with registered read
module lpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         q
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q <= mem[raddr];
    end

endmodule

### hdl/lpe_core.sv
// parse sequencer: tokenizer, stack pointer, pop/match/expand steps and result
module lpe_core
    import lpe_pkg::*;
#(
    parameter int STACK_DEPTH  = 64,
    parameter int MAX_PROD_LEN = 8,
    parameter int STEP_LIMIT   = 256,
    localparam int AW = $clog2(STACK_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          kind,
    input  logic [SYM_W-1:0]    char_code,
    input  logic [SYM_W-1:0]    lookahead,
    input  logic [LEN_W-1:0]    prod_length,
    input  logic [SYMS_W-1:0]   prod_symbols,
    input  logic                flag_value,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SYM_W-1:0]    start_symbol,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                accepted,
    output logic [1:0]          error_cause,
    output tbl_req_t            tbl_req,
    input  logic [ENTRY_W-1:0]  tbl_q,
    output flg_req_t            flg_req,
    input  logic                flg_q,
    output logic                stk_we,
    output logic [AW-1:0]       stk_waddr,
    output logic [SYM_W-1:0]    stk_wdata,
    output logic [AW-1:0]       stk_raddr,
    input  logic [SYM_W-1:0]    stk_q
);

    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int SW   = $clog2(STEP_LIMIT + 1);
    localparam int SUMW = ((CW > LEN_W) ? CW : LEN_W) + 1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CHAR, ST_POP, ST_TOP, ST_EVAL, ST_PUSH, ST_RESULT
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [SYM_W-1:0]    slot1_reg, slot1_next;
    logic [SYM_W-1:0]    start_reg, start_next;
    logic                pending_reg, pending_next;
    logic [1:0]          err_reg, err_next;
    logic                fin_reg, fin_next;
    logic [SW-1:0]       step_reg, step_next;
    logic [SYM_W-1:0]    tok_reg, tok_next;
    logic [SYM_W-1:0]    second_reg, second_next;
    logic                have2_reg, have2_next;
    logic                isend_reg, isend_next;
    logic [SYM_W-1:0]    top_reg, top_next;
    logic [AW-1:0]       raddr_reg, raddr_next;
    logic [ENTRY_W-1:0]  entry_reg, entry_next;
    logic [LEN_W-1:0]    pidx_reg, pidx_next;
    logic [TBL_AW-1:0]   clr_reg, clr_next;
    logic [FLG_DEPTH-1:0] fvld_reg, fvld_next;
    logic                fhit_reg;
    logic                out_valid_reg, out_valid_next;
    logic                acc_reg, acc_next;
    logic [1:0]          cause_reg, cause_next;

    logic                take;
    logic                feed_done;
    logic                reseed;
    logic [SYM_W-1:0]    top_c;
    logic [LEN_W-1:0]    len_sat;
    logic [SYMS_W-1:0]   syms_m;
    logic [SUMW-1:0]     need;
    logic [2:0]          sidx;

    assign in_stall    = (state_reg != ST_IDLE);
    assign cfg_ready   = (state_reg == ST_IDLE) || (state_reg == ST_CLEAR);
    assign take        = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign accepted    = acc_reg;
    assign error_cause = cause_reg;

    assign top_c = (raddr_reg == AW'(0)) ? END_MARK :
                   (raddr_reg == AW'(1)) ? slot1_reg : stk_q;
    assign need  = SUMW'(count_reg) + SUMW'(tbl_q[ENTRY_W-2 -: LEN_W]);
    assign sidx  = 3'(pidx_reg - LEN_W'(1));

    always_comb
    begin
        len_sat = (prod_length > LEN_W'(MAX_PROD_LEN)) ? LEN_W'(MAX_PROD_LEN) : prod_length;
        for (int i = 0; i < NSYM; i++)
        begin
            syms_m[i*SYM_W +: SYM_W] = (LEN_W'(i) < len_sat) ?
                                       prod_symbols[i*SYM_W +: SYM_W] : '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        slot1_next     = slot1_reg;
        start_next     = start_reg;
        pending_next   = pending_reg;
        err_next       = err_reg;
        fin_next       = fin_reg;
        step_next      = step_reg;
        tok_next       = tok_reg;
        second_next    = second_reg;
        have2_next     = have2_reg;
        isend_next     = isend_reg;
        top_next       = top_reg;
        raddr_next     = raddr_reg;
        entry_next     = entry_reg;
        pidx_next      = pidx_reg;
        clr_next       = clr_reg;
        fvld_next      = fvld_reg;
        acc_next       = acc_reg;
        cause_next     = cause_reg;
        out_valid_next = out_valid_reg && out_stall;
        feed_done      = 1'b0;
        reseed         = 1'b0;

        tbl_req.we     = 1'b0;
        tbl_req.waddr  = {char_code, lookahead};
        tbl_req.wdata  = flag_value ? {1'b1, len_sat, syms_m} : '0;
        tbl_req.raddr  = {top_c, tok_reg};
        flg_req.we     = 1'b0;
        flg_req.waddr  = char_code;
        flg_req.wdata  = flag_value;
        flg_req.raddr  = (state_reg == ST_IDLE) ? char_code : top_c;
        stk_we         = 1'b0;
        stk_waddr      = count_reg[AW-1:0];
        stk_wdata      = entry_reg[32'(sidx) * SYM_W +: SYM_W];
        stk_raddr      = AW'(count_reg - CW'(1));

        unique case (state_reg)
            ST_CLEAR:
            begin
                tbl_req.we    = 1'b1;
                tbl_req.waddr = clr_reg;
                tbl_req.wdata = '0;
                clr_next      = clr_reg + TBL_AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    unique case (kind)
                        KIND_LOAD:
                        begin
                            tbl_req.we = 1'b1;
                        end
                        KIND_FLAG:
                        begin
                            flg_req.we           = 1'b1;
                            fvld_next[char_code] = 1'b1;
                        end
                        KIND_CHAR:
                        begin
                            state_next = ST_CHAR;
                        end
                        KIND_END:
                        begin
                            isend_next   = 1'b1;
                            pending_next = 1'b0;
                            second_next  = END_MARK;
                            have2_next   = pending_reg;
                            tok_next     = pending_reg ? IDENT_TOKEN : END_MARK;
                            state_next   = ST_POP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHAR:
            begin
                state_next = ST_IDLE;
                if (err_reg == ERR_NONE && !fin_reg)
                begin
                    if (flg_q && fhit_reg)
                    begin
                        isend_next   = 1'b0;
                        pending_next = 1'b0;
                        second_next  = second_reg;
                        have2_next   = pending_reg;
                        tok_next     = pending_reg ? IDENT_TOKEN : tok_reg;
                        state_next   = ST_POP;
                    end
                    else
                    begin
                        pending_next = 1'b1;
                    end
                end
            end
            ST_POP:
            begin
                if (err_reg != ERR_NONE || fin_reg)
                begin
                    feed_done = 1'b1;
                end
                else if (step_reg >= SW'(STEP_LIMIT))
                begin
                    err_next  = ERR_LIMIT;
                    feed_done = 1'b1;
                end
                else if (count_reg == '0)
                begin
                    step_next = step_reg + SW'(1);
                    err_next  = ERR_MISMATCH;
                    feed_done = 1'b1;
                end
                else
                begin
                    step_next  = step_reg + SW'(1);
                    count_next = count_reg - CW'(1);
                    raddr_next = stk_raddr;
                    state_next = ST_TOP;
                end
            end
            ST_TOP:
            begin
                top_next   = top_c;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (top_reg == END_MARK)
                begin
                    if (tok_reg == END_MARK)
                    begin
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        err_next = ERR_MISMATCH;
                    end
                    feed_done = 1'b1;
                end
                else if (flg_q && fhit_reg)
                begin
                    if (top_reg != tok_reg)
                    begin
                        err_next = ERR_MISMATCH;
                    end
                    feed_done = 1'b1;
                end
                else if (!tbl_q[ENTRY_W-1])
                begin
                    err_next  = ERR_NO_ENTRY;
                    feed_done = 1'b1;
                end
                else if (need > SUMW'(STACK_DEPTH))
                begin
                    err_next  = ERR_LIMIT;
                    feed_done = 1'b1;
                end
                else
                begin
                    entry_next = tbl_q;
                    pidx_next  = tbl_q[ENTRY_W-2 -: LEN_W];
                    state_next = (tbl_q[ENTRY_W-2 -: LEN_W] == '0) ? ST_POP : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (count_reg == CW'(1))
                begin
                    slot1_next = stk_wdata;
                end
                else
                begin
                    stk_we = 1'b1;
                end
                count_next = count_reg + CW'(1);
                pidx_next  = pidx_reg - LEN_W'(1);
                if (pidx_reg == LEN_W'(1))
                begin
                    state_next = ST_POP;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    acc_next       = (err_reg == ERR_NONE) && fin_reg;
                    cause_next     = (err_reg != ERR_NONE) ? err_reg :
                                     fin_reg ? ERR_NONE : ERR_MISMATCH;
                    reseed         = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_reg == ST_IDLE && take && kind == KIND_CHAR)
        begin
            tok_next    = char_code;
            second_next = char_code;
        end

        if (feed_done)
        begin
            if (have2_reg)
            begin
                tok_next   = second_reg;
                have2_next = 1'b0;
                state_next = ST_POP;
            end
            else if (isend_reg)
            begin
                state_next = ST_RESULT;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end

        if (cfg_valid && cfg_ready)
        begin
            start_next = start_symbol;
            reseed     = 1'b1;
        end

        if (reseed)
        begin
            slot1_next   = start_next;
            count_next   = CW'(2);
            pending_next = 1'b0;
            err_next     = ERR_NONE;
            fin_next     = 1'b0;
            step_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            count_reg     <= CW'(2);
            slot1_reg     <= START_RESET;
            start_reg     <= START_RESET;
            pending_reg   <= 1'b0;
            err_reg       <= ERR_NONE;
            fin_reg       <= 1'b0;
            step_reg      <= '0;
            tok_reg       <= '0;
            second_reg    <= '0;
            have2_reg     <= 1'b0;
            isend_reg     <= 1'b0;
            top_reg       <= '0;
            raddr_reg     <= '0;
            entry_reg     <= '0;
            pidx_reg      <= '0;
            clr_reg       <= '0;
            fvld_reg      <= '0;
            fhit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= 1'b0;
            cause_reg     <= ERR_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            slot1_reg     <= slot1_next;
            start_reg     <= start_next;
            pending_reg   <= pending_next;
            err_reg       <= err_next;
            fin_reg       <= fin_next;
            step_reg      <= step_next;
            tok_reg       <= tok_next;
            second_reg    <= second_next;
            have2_reg     <= have2_next;
            isend_reg     <= isend_next;
            top_reg       <= top_next;
            raddr_reg     <= raddr_next;
            entry_reg     <= entry_next;
            pidx_reg      <= pidx_next;
            clr_reg       <= clr_next;
            fvld_reg      <= fvld_next;
            fhit_reg      <= fvld_reg[flg_req.raddr];
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            cause_reg     <= cause_next;
        end
    end

    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> error_cause == ERR_NONE)
        else $error("accept reported with an error cause");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> in_stall)
        else $error("item taken during table clear");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        stk_we |-> count_reg < CW'(STACK_DEPTH) && count_reg >= CW'(2))
        else $error("stack write outside the ram");

endmodule

### verif/testbench.sv
// self-checking testbench for the ll(1) predictive parse engine
`timescale 1ns / 100ps

module testbench;
    import lpe_pkg::*;

    localparam int STACK_LIM = 64;
    localparam int STEP_LIM  = 256;

    typedef struct packed {
        logic       acc;
        logic [1:0] cause;
    } verdict_t;

    class verdict_board;
        verdict_t pending[$];
        int errors;
        function void note(verdict_t v);
            pending.push_back(v);
        endfunction
        function void check(logic acc, logic [1:0] cause);
            verdict_t v;
            if (pending.size() == 0) begin
                $error("unexpected result beat acc=%0d cause=%0d", acc, cause);
                errors++;
                return;
            end
            v = pending.pop_front();
            if (acc !== v.acc) begin
                $error("accepted expected %0d got %0d", v.acc, acc);
                errors++;
            end
            if (cause !== v.cause) begin
                $error("error_cause expected %0d got %0d", v.cause, cause);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [1:0] kind = 0;
    logic [SYM_W-1:0] char_code = 0;
    logic [SYM_W-1:0] lookahead = 0;
    logic [LEN_W-1:0] prod_length = 0;
    logic [SYMS_W-1:0] prod_symbols = 0;
    logic flag_value = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [SYM_W-1:0] start_symbol = 0;
    logic out_valid;
    logic out_stall = 0;
    logic accepted;
    logic [1:0] error_cause;

    ll1_predictive_parse_engine_top dut (.*);

    always #5 clk = ~clk;

    verdict_board board = new();

    // predictor state
    logic [ENTRY_W-1:0] grammar [TBL_DEPTH];
    logic               term_flag [FLG_DEPTH];
    logic [SYM_W-1:0]   pstack [STACK_LIM];
    int                 depth;
    logic               ident_open;
    logic [1:0]         line_err;
    logic               line_done;
    int                 pops;
    logic [SYM_W-1:0]   start_cur;
    bit                 hold_long;

    function void reseed();
        pstack[0] = END_MARK;
        pstack[1] = start_cur;
        depth = 2;
        ident_open = 0;
        line_err = ERR_NONE;
        line_done = 0;
        pops = 0;
    endfunction

    function void parse_token(logic [SYM_W-1:0] tok);
        logic [SYM_W-1:0] top;
        logic [ENTRY_W-1:0] e;
        int n;
        forever begin
            if (line_err != ERR_NONE || line_done) return;
            if (pops >= STEP_LIM) begin
                line_err = ERR_LIMIT;
                return;
            end
            pops++;
            if (depth == 0) begin
                line_err = ERR_MISMATCH;
                return;
            end
            depth--;
            top = pstack[depth];
            if (top == END_MARK) begin
                if (tok == END_MARK) line_done = 1;
                else line_err = ERR_MISMATCH;
                return;
            end
            if (term_flag[top]) begin
                if (top != tok) line_err = ERR_MISMATCH;
                return;
            end
            e = grammar[{top, tok}];
            if (!e[ENTRY_W-1]) begin
                line_err = ERR_NO_ENTRY;
                return;
            end
            n = int'(e[SYMS_W +: LEN_W]);
            if (depth + n > STACK_LIM) begin
                line_err = ERR_LIMIT;
                return;
            end
            for (int i = n; i > 0; i--) begin
                pstack[depth] = e[SYM_W*(i-1) +: SYM_W];
                depth++;
            end
        end
    endfunction

    function void predict(logic [1:0] k, logic [SYM_W-1:0] c, logic [SYM_W-1:0] la,
                          logic [LEN_W-1:0] ln, logic [SYMS_W-1:0] sy, logic fv);
        verdict_t v;
        logic [ENTRY_W-1:0] e;
        int n;
        case (k)
            KIND_LOAD:
            begin
                n = (int'(ln) > NSYM) ? NSYM : int'(ln);
                e = '0;
                if (fv) begin
                    e[ENTRY_W-1] = 1'b1;
                    e[SYMS_W +: LEN_W] = LEN_W'(n);
                    for (int i = 0; i < n; i++) e[SYM_W*i +: SYM_W] = sy[SYM_W*i +: SYM_W];
                end
                grammar[{c, la}] = e;
            end
            KIND_FLAG: term_flag[c] = fv;
            KIND_CHAR:
            begin
                if (line_err == ERR_NONE && !line_done) begin
                    if (term_flag[c]) begin
                        if (ident_open) begin
                            ident_open = 0;
                            parse_token(IDENT_TOKEN);
                        end
                        parse_token(c);
                    end else begin
                        ident_open = 1;
                    end
                end
            end
            default:
            begin
                if (ident_open) begin
                    ident_open = 0;
                    parse_token(IDENT_TOKEN);
                end
                parse_token(END_MARK);
                if (line_err != ERR_NONE) v = '{1'b0, line_err};
                else if (line_done) v = '{1'b1, ERR_NONE};
                else v = '{1'b0, ERR_MISMATCH};
                board.note(v);
                reseed();
            end
        endcase
    endfunction

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(logic [1:0] k, logic [SYM_W-1:0] c, logic [SYM_W-1:0] la = 0,
                        logic [LEN_W-1:0] ln = 0, logic [SYMS_W-1:0] sy = 0,
                        logic fv = 0, bit nogap = 0);
        int g;
        g = nogap ? 0 : gap_len();
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        kind <= k;
        char_code <= c;
        lookahead <= la;
        prod_length <= ln;
        prod_symbols <= sy;
        flag_value <= fv;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict(k, c, la, ln, sy, fv);
    endtask

    task automatic load_rule(byte nt, byte la, string rhs);
        logic [SYMS_W-1:0] sy;
        sy = '0;
        for (int i = 0; i < rhs.len(); i++) sy[SYM_W*i +: SYM_W] = SYM_W'(rhs[i]);
        send(KIND_LOAD, SYM_W'(nt), SYM_W'(la), LEN_W'(rhs.len()), sy, 1);
    endtask

    task automatic send_line(string s);
        for (int i = 0; i < s.len(); i++) send(KIND_CHAR, SYM_W'(s[i]));
        send(KIND_END, 0);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_start(logic [SYM_W-1:0] s);
        start_symbol <= s;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        start_cur = s;
        reseed();
    endtask

    // expression grammar: E->TR  R->+TR|e  T->FS  S->*FS|e  F->(E)|i
    task automatic load_grammar();
        string tsyms;
        tsyms = "i+*()";
        foreach (tsyms[j]) send(KIND_FLAG, SYM_W'(tsyms[j]), 0, 0, 0, 1);
        send(KIND_FLAG, END_MARK, 0, 0, 0, 1);
        load_rule("E", "i", "TR");
        load_rule("E", "(", "TR");
        load_rule("R", "+", "+TR");
        load_rule("R", ")", "");
        load_rule("R", "#", "");
        load_rule("T", "i", "FS");
        load_rule("T", "(", "FS");
        load_rule("S", "+", "");
        load_rule("S", "*", "*FS");
        load_rule("S", ")", "");
        load_rule("S", "#", "");
        load_rule("F", "i", "i");
        load_rule("F", "(", "(E)");
    endtask

    function string rand_expr(int lvl);
        string s;
        int r;
        r = $urandom_range(0, 9);
        if (lvl > 3 || r < 4) begin
            s = "";
            repeat ($urandom_range(1, 3)) s = {s, string'(8'($urandom_range(97, 104)))};
            return s;
        end
        if (r < 6) return {"(", rand_expr(lvl + 1), ")"};
        if (r < 8) return {rand_expr(lvl + 1), "+", rand_expr(lvl + 1)};
        return {rand_expr(lvl + 1), "*", rand_expr(lvl + 1)};
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check(accepted, error_cause);
    end

    always @(posedge clk) begin
        int g;
        if (hold_long) out_stall <= 1;
        else begin
            g = $urandom_range(0, 99);
            out_stall <= (g < 25);
        end
    end

    initial begin
        #60_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        string e;
        int sent;
        logic [SYMS_W-1:0] sy;
        hold_long = 0;
        for (int i = 0; i < TBL_DEPTH; i++) grammar[i] = '0;
        for (int i = 0; i < FLG_DEPTH; i++) term_flag[i] = 0;
        start_cur = START_RESET;
        reseed();
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed
        send_line("a");
        load_grammar();
        send_line("x+y*z");
        send_line("(a+b");
        send_line("a)");
        send_line("+");
        send_line("");
        send(KIND_CHAR, SYM_W'("a"));
        send(KIND_CHAR, SYM_W'("+"));
        send(KIND_CHAR, SYM_W'("+"));
        send(KIND_END, 0);
        sy = {SYMS_W{1'b1}};
        send(KIND_LOAD, 7'h7f, 7'h7f, 4'hf, sy, 1);
        send(KIND_LOAD, 7'h7f, 7'h7f, 4'hf, sy, 0);
        send(KIND_FLAG, 7'h7f, 0, 0, 0, 0);
        drain();

        // deep nesting hits stack overflow and step limit
        e = "";
        repeat (30) e = {e, "("};
        send_line({e, "a"});
        e = "";
        repeat (80) e = {e, "a+"};
        send_line({e, "a"});
        drain();

        write_start(7'h00);
        send_line("a");
        drain();
        write_start(7'h7f);
        send_line("a");
        drain();
        write_start(SYM_W'("T"));
        send_line("a*b");
        send_line("a+b");
        drain();
        write_start(SYM_W'("E"));

        // back-pressure: receiver holds off while lines keep coming
        hold_long = 1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_long = 0;
            end
            begin
                for (int i = 0; i < 12; i++) begin
                    e = rand_expr(0);
                    for (int j = 0; j < e.len(); j++)
                        send(KIND_CHAR, SYM_W'(e[j]), 0, 0, 0, 0, 1);
                    send(KIND_END, 0, 0, 0, 0, 0, 1);
                end
            end
        join

        sent = 0;
        while (sent < 1750) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 75) begin
                e = rand_expr(0);
                if ($urandom_range(0, 9) == 0) e[$urandom_range(0, e.len() - 1)] = "+";
                send_line(e);
                sent += e.len() + 1;
            end else if (r < 85) begin
                send(KIND_CHAR, SYM_W'($urandom_range(0, 127)));
                sent++;
            end else if (r < 90) begin
                send(KIND_END, SYM_W'($urandom), SYM_W'($urandom), LEN_W'($urandom),
                     SYMS_W'({$urandom, $urandom}), 1'($urandom));
                sent++;
            end else if (r < 95) begin
                send(KIND_LOAD, SYM_W'($urandom), SYM_W'($urandom), LEN_W'($urandom),
                     SYMS_W'({$urandom, $urandom}), 1'($urandom));
                sent++;
            end else begin
                send(KIND_FLAG, SYM_W'($urandom_range(0, 127)), 0, 0, 0, 1'($urandom));
                sent++;
            end
            if (r >= 90 && $urandom_range(0, 3) == 0) begin
                drain();
                load_grammar();
            end
        end
        drain();
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule

### sim.f
hdl/lpe_pkg.sv
hdl/lpe_ram.sv
hdl/lpe_core.sv
hdl/ll1_predictive_parse_engine_top.sv
verif/testbench.sv
